// ----- rtl/ntc_temperature_rgb_dimmer_macros.svh -----
// Assertion macros for the dimmer RTL
`ifndef NTC_TEMPERATURE_RGB_DIMMER_MACROS_SVH
`define NTC_TEMPERATURE_RGB_DIMMER_MACROS_SVH

// same-cycle implication, checked on clk, held off in reset
`define NTCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NTCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ntcd_pkg.sv -----
// Types and constants of the NTC temperature RGB dimmer
package ntcd_pkg;

  localparam int MV_W    = 12;
  localparam int TEMP_W  = 18;
  localparam int DUTY_W  = 12;
  localparam int CFG_I_W = 2;

  typedef enum logic [CFG_I_W-1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2
  } cfg_idx_t;

  localparam logic signed [TEMP_W-1:0] RED_THR_RST   = 18'sd2800;
  localparam logic signed [TEMP_W-1:0] GREEN_THR_RST = 18'sd2000;
  localparam logic signed [TEMP_W-1:0] BLUE_THR_RST  = 18'sd0;

  // log2 unit: Q28 result, Q30 mantissa
  localparam int LG_A_W   = 19;
  localparam int LG_E_W   = 5;
  localparam int LG_M_W   = 31;
  localparam int LG_FRAC  = 28;
  localparam int LG_R_W   = 33;

  // divider
  localparam int DIV_D_W  = 48;
  localparam int DIV_N_W  = 64;
  localparam int DIV_Q_W  = 18;

  localparam logic [29:0]          LN2_Q30   = 30'd744261118;
  localparam logic [DIV_N_W-1:0]   KNUM      = 64'd11776925000;
  localparam logic [DIV_D_W-1:0]   D_BASE    = 48'd106032005120000;
  localparam logic [14:0]          T0_CENTI  = 15'd29815;
  localparam logic [18:0]          KELVIN_OFS = 19'd27315;
  localparam logic signed [18:0]   TEMP_MIN  = -19'sd10000;
  localparam logic signed [18:0]   TEMP_MAX  = 19'sd80000;

  // duty = floor(pot*273/220), 220 divide by reciprocal
  localparam logic [8:0]           DUTY_MUL  = 9'd273;
  localparam logic [20:0]          DUTY_RCP  = 21'd1220162;
  localparam logic [MV_W-1:0]      POT_FULL  = 12'd3300;
  localparam logic [DUTY_W-1:0]    DUTY_MAX  = 12'd4095;

  localparam logic [MV_W-1:0]      MV_FULL   = 12'd3300;

endpackage

// ----- rtl/ntcd_sample_if.sv -----
// Input channel: thermistor and pot voltages
interface ntcd_sample_if;
  logic                         valid;
  logic                         ready;
  logic [ntcd_pkg::MV_W-1:0]    ntc_millivolts;
  logic [ntcd_pkg::MV_W-1:0]    pot_millivolts;

  modport source (output valid, ntc_millivolts, pot_millivolts, input ready);
  modport sink   (input valid, ntc_millivolts, pot_millivolts, output ready);
endinterface

// ----- rtl/ntcd_result_if.sv -----
// Output channel: temperature and RGB duties
interface ntcd_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [ntcd_pkg::TEMP_W-1:0] temperature_centi;
  logic [ntcd_pkg::DUTY_W-1:0]        duty_red;
  logic [ntcd_pkg::DUTY_W-1:0]        duty_green;
  logic [ntcd_pkg::DUTY_W-1:0]        duty_blue;

  modport source (output valid, temperature_centi, duty_red, duty_green, duty_blue,
                  input ready);
  modport sink   (input valid, temperature_centi, duty_red, duty_green, duty_blue,
                  output ready);
endinterface

// ----- rtl/ntc_temperature_rgb_dimmer.sv -----
// Top level: NTC thermistor temperature and pot brightness to RGB duties
//
//  channel   dir  transaction payload
//  samples   in   ntc_millivolts, pot_millivolts
//  results   out  temperature_centi, duty_red, duty_green, duty_blue
//  cfg_*     in   register write, index 0..2 = red/green/blue threshold
//
// One sample per cycle unless a held result stalls; accept to result runs
// through the 28-stage squaring log2 and the 18-stage quotient pipelines.
// rst is synchronous: clears valid bits and loads threshold defaults.
// A result held at the output freezes the whole pipeline; nothing is dropped.

`include "ntc_temperature_rgb_dimmer_macros.svh"

module ntc_temperature_rgb_dimmer (
  input  logic                                clk,
  input  logic                                rst,
  ntcd_sample_if.sink                         samples,
  ntcd_result_if.source                       results,
  input  logic                                cfg_we,
  input  logic [ntcd_pkg::CFG_I_W-1:0]        cfg_index,
  input  logic [ntcd_pkg::TEMP_W-1:0]         cfg_data
);

  localparam int NST = 54;
  localparam int S_DIV = 53;   // quotient ready

  logic en;
  logic [NST:1] vld;

  logic signed [ntcd_pkg::TEMP_W-1:0] red_thr, green_thr, blue_thr;

  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      red_thr   <= ntcd_pkg::RED_THR_RST;
      green_thr <= ntcd_pkg::GREEN_THR_RST;
      blue_thr  <= ntcd_pkg::BLUE_THR_RST;
    end else if (cfg_we) begin
      case (ntcd_pkg::cfg_idx_t'(cfg_index))
        ntcd_pkg::CFG_RED:   red_thr   <= $signed(cfg_data);
        ntcd_pkg::CFG_GREEN: green_thr <= $signed(cfg_data);
        ntcd_pkg::CFG_BLUE:  blue_thr  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], samples.valid};
    end
  end

  // divider voltage to resistance ratio num/den
  logic [15:0]                 v10;
  logic [25:0]                 v10x;
  logic                        tiny_r;
  logic [ntcd_pkg::LG_A_W-1:0] num, den;

  always_comb begin
    if (samples.ntc_millivolts == '0) begin
      v10 = 16'd1;
    end else if (samples.ntc_millivolts >= ntcd_pkg::MV_FULL) begin
      v10 = 16'd32999;
    end else begin
      v10 = 16'(samples.ntc_millivolts) * 16'd10;
    end
    v10x   = 26'(v10) * 26'd1001;
    tiny_r = v10x <= 26'd33000;
    num    = tiny_r ? ntcd_pkg::LG_A_W'(1) : ntcd_pkg::LG_A_W'(v10);
    den    = tiny_r ? ntcd_pkg::LG_A_W'(10000)
                    : ntcd_pkg::LG_A_W'((20'd33000 - 20'(v10)) * 20'd10);
  end

  logic [ntcd_pkg::LG_R_W-1:0] lg_num, lg_den;

  ntcd_log2 u_lg_num (.clk(clk), .en(en), .a(num), .r(lg_num));
  ntcd_log2 u_lg_den (.clk(clk), .en(en), .a(den), .r(lg_den));

  // brightness path, carried alongside
  logic [20:0]                   p273_q;
  logic                          pot_sat_q;
  logic [41:0]                   duty_prod;
  logic [ntcd_pkg::DUTY_W-1:0]   dq [2:S_DIV];

  assign duty_prod = 42'(p273_q) * 42'(ntcd_pkg::DUTY_RCP);

  always_ff @(posedge clk) begin
    if (en) begin
      p273_q    <= 21'(samples.pot_millivolts) * 21'(ntcd_pkg::DUTY_MUL);
      pot_sat_q <= samples.pot_millivolts >= ntcd_pkg::POT_FULL;
      dq[2]     <= pot_sat_q ? ntcd_pkg::DUTY_MAX : duty_prod[39:28];
      for (int i = 3; i <= S_DIV; i++) dq[i] <= dq[i-1];
    end
  end

  // ln ratio, then beta denominator D
  logic signed [ntcd_pkg::LG_R_W:0] l_diff;
  logic [ntcd_pkg::LG_R_W-1:0]      mag_q;
  logic                             neg30, neg31, neg32, neg33;
  logic [45:0]                      pph_q;
  logic [46:0]                      ppl_q;
  logic [63:0]                      ln_sum;
  logic [32:0]                      xm_q;
  logic [ntcd_pkg::DIV_D_W-1:0]     sc_q, d_q;

  assign l_diff = $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});
  assign ln_sum = (64'(pph_q) << 17) + 64'(ppl_q);

  always_ff @(posedge clk) begin
    if (en) begin
      neg30 <= l_diff[ntcd_pkg::LG_R_W];
      mag_q <= l_diff[ntcd_pkg::LG_R_W] ? ntcd_pkg::LG_R_W'(-l_diff)
                                         : ntcd_pkg::LG_R_W'(l_diff);
      neg31 <= neg30;
      pph_q <= 46'(mag_q[32:17]) * 46'(ntcd_pkg::LN2_Q30);
      ppl_q <= 47'(mag_q[16:0]) * 47'(ntcd_pkg::LN2_Q30);
      neg32 <= neg31;
      xm_q  <= ln_sum[62:30];
      neg33 <= neg32;
      sc_q  <= 48'(xm_q) * 48'(ntcd_pkg::T0_CENTI);
      d_q   <= neg33 ? ntcd_pkg::D_BASE - sc_q : ntcd_pkg::D_BASE + sc_q;
    end
  end

  logic [ntcd_pkg::DIV_Q_W-1:0] kq;

  ntcd_div u_div (.clk(clk), .en(en), .d(d_q), .q(kq));

  // kelvin to celsius, thresholds, output register
  logic signed [18:0]                 c_raw;
  logic signed [ntcd_pkg::TEMP_W-1:0] c_sat;

  always_comb begin
    c_raw = $signed({1'b0, kq}) - $signed(ntcd_pkg::KELVIN_OFS);
    if (c_raw < ntcd_pkg::TEMP_MIN)      c_sat = ntcd_pkg::TEMP_W'(ntcd_pkg::TEMP_MIN);
    else if (c_raw > ntcd_pkg::TEMP_MAX) c_sat = ntcd_pkg::TEMP_W'(ntcd_pkg::TEMP_MAX);
    else                                 c_sat = ntcd_pkg::TEMP_W'(c_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.temperature_centi <= c_sat;
      results.duty_red   <= (c_sat >= red_thr)   ? dq[S_DIV] : '0;
      results.duty_green <= (c_sat >= green_thr) ? dq[S_DIV] : '0;
      results.duty_blue  <= (c_sat >= blue_thr)  ? dq[S_DIV] : '0;
    end
  end

  assign results.valid = vld[NST];

  `NTCD_ASSERT_IMP(a_stall_freezes, results.valid && !results.ready, !samples.ready, "stall did not hold input")
  `NTCD_ASSERT_IMP(a_red_thr, results.valid && results.duty_red != '0, results.temperature_centi >= red_thr, "red lit below threshold")
  `NTCD_ASSERT_IMP(a_same_duty, results.valid && results.duty_red != '0 && results.duty_blue != '0, results.duty_red == results.duty_blue, "lit channels differ in duty")

endmodule

// ----- rtl/ntcd_log2.sv -----
// Pipelined log2 in Q28 by repeated squaring, one result bit per stage
module ntcd_log2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ntcd_pkg::LG_A_W-1:0]   a,
  output logic [ntcd_pkg::LG_R_W-1:0]   r
);

  localparam int NB = ntcd_pkg::LG_FRAC;

  logic [ntcd_pkg::LG_M_W-1:0] m_q [0:NB];
  logic [ntcd_pkg::LG_R_W-1:0] r_q [0:NB];

  logic [ntcd_pkg::LG_E_W-1:0] e;
  logic [ntcd_pkg::LG_A_W-1:0] a_nz;

  // leading one
  always_comb begin
    a_nz = (a == '0) ? ntcd_pkg::LG_A_W'(1) : a;
    e = '0;
    for (int i = 0; i < ntcd_pkg::LG_A_W; i++) begin
      if (a_nz[i]) e = ntcd_pkg::LG_E_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0] <= ntcd_pkg::LG_M_W'(a_nz) << (ntcd_pkg::LG_E_W'(30) - e);
      r_q[0] <= ntcd_pkg::LG_R_W'(e) << NB;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_sq
    logic [2*ntcd_pkg::LG_M_W-1:0] sq;
    logic [ntcd_pkg::LG_M_W:0]     t;
    assign sq = m_q[k] * m_q[k];
    assign t  = sq[2*ntcd_pkg::LG_M_W-1:30];

    always_ff @(posedge clk) begin
      if (en) begin
        if (t[ntcd_pkg::LG_M_W]) begin
          m_q[k+1] <= t[ntcd_pkg::LG_M_W:1];
          r_q[k+1] <= r_q[k] | (ntcd_pkg::LG_R_W'(1) << (NB-1-k));
        end else begin
          m_q[k+1] <= t[ntcd_pkg::LG_M_W-1:0];
          r_q[k+1] <= r_q[k];
        end
      end
    end
  end

  assign r = r_q[NB];

endmodule

// ----- rtl/ntcd_div.sv -----
// Pipelined restoring divide: q = (KNUM*2^29 + d) / (2d), one bit per stage
module ntcd_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ntcd_pkg::DIV_D_W-1:0]  d,
  output logic [ntcd_pkg::DIV_Q_W-1:0]  q
);

  localparam int QW = ntcd_pkg::DIV_Q_W;
  localparam int NW = ntcd_pkg::DIV_N_W;
  localparam int VW = ntcd_pkg::DIV_D_W + 1;
  localparam int CW = VW + QW;

  logic [NW-1:0] rem_q [0:QW];
  logic [VW-1:0] dv_q  [0:QW];
  logic [QW-1:0] qa_q  [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= (ntcd_pkg::KNUM << 29) + NW'(d);
      dv_q[0]  <= {d, 1'b0};
      qa_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(dv_q[k]) << (QW-1-k);
    assign ge = CW'(rem_q[k]) >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? NW'(CW'(rem_q[k]) - sh) : rem_q[k];
        dv_q[k+1]  <= dv_q[k];
        qa_q[k+1]  <= qa_q[k] | (ge ? (QW'(1) << (QW-1-k)) : '0);
      end
    end
  end

  assign q = qa_q[QW];

endmodule
